[src/spime_pkg.sv]
// Shared constants for the SPI master mode engine.
// No dependencies; imported by spi_master_mode_engine.
package spime_pkg;

    // Default shift word length
    localparam int WORD_BITS_DEF = 8;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int HALF_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_IDLE_HIGH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_ON_SECOND_EDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS     = 2'd2;

    // Reset value of the half period register
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd1;

endpackage

[src/spi_master_mode_engine.sv]
// SPI master engine for clock modes 0 to 3, one item per timing tick.
// Depends on spime_pkg for field widths and configuration indexes.
//
// Usage: each item accepted on the s_ channel is one timing tick. A tick
// with s_action high loads a new word when no word is in flight; every
// tick yields exactly one item on the m_ channel with the pin levels
// (sclk, mosi, chip select) after that tick, plus rx_byte/rx_valid when a
// word completes, ready_res when the load was taken and transfer_done when
// chip select is released.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes
// are taken every cycle (cfg_ready is always high), index 3 is ignored.
// Results are registered: each appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while results are taken; the whole state
// update is a single pass of logic into the state and result registers.
// Stall: s_ready is high while the result register is empty or being
// taken, so a stalled receiver holds off new ticks with no item lost.
// Reset (aresetn low, synchronous): clock idle low, first-edge sampling,
// half period 1, no word in flight, chip select released, no result held.
module spi_master_mode_engine #(
    parameter int WORD_BITS = spime_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spime_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spime_pkg::HALF_W-1:0]  cfg_data,
    // Tick input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [spime_pkg::BYTE_W-1:0]  s_tx_byte,
    input  logic                          s_tx_present,
    input  logic                          s_last_byte,
    input  logic                          s_miso_level,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_sclk_level,
    output logic                          m_mosi_level,
    output logic                          m_chip_select_n,
    output logic [spime_pkg::BYTE_W-1:0]  m_rx_byte,
    output logic                          m_rx_valid,
    output logic                          m_ready_res,
    output logic                          m_transfer_done
);
    import spime_pkg::*;

    localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int EXT_W = (WORD_BITS > BYTE_W) ? WORD_BITS : BYTE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);

    // Configuration registers
    logic              clock_idle_high_reg;
    logic              sample_second_reg;
    logic [HALF_W-1:0] half_period_reg;

    // Engine state
    logic [WORD_BITS-1:0] tx_shift_reg,  tx_shift_next;
    logic [WORD_BITS-1:0] rx_shift_reg,  rx_shift_next;
    logic [IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic                 edge_phase_reg, edge_phase_next;
    logic [HALF_W-1:0]    delay_count_reg, delay_count_next;
    logic                 byte_active_reg, byte_active_next;
    logic                 select_active_reg, select_active_next;
    logic                 ending_reg, ending_next;

    // Result register
    logic                 m_valid_reg;
    logic                 sclk_reg, mosi_reg, csn_reg;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic                 rx_valid_reg, ready_res_reg, done_reg;

    // Combinational results for the current tick
    logic                 sclk_next, mosi_next;
    logic [BYTE_W-1:0]    rx_byte_next;
    logic                 rx_valid_next, ready_res_next, done_next;
    logic [HALF_W-1:0]    period;
    logic [HALF_W-1:0]    delay_inc;
    logic [EXT_W-1:0]     tx_ext;
    logic [EXT_W-1:0]     rx_ext;
    logic                 s_take;
    logic                 sclk_at_active;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_take    = s_valid && s_ready;

    assign period    = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;
    assign delay_inc = delay_count_reg + HALF_W'(1);
    assign tx_ext    = EXT_W'(s_tx_byte);

    // Tick update: load, count half periods, shift bits
    always_comb begin
        tx_shift_next      = tx_shift_reg;
        rx_shift_next      = rx_shift_reg;
        bit_index_next     = bit_index_reg;
        edge_phase_next    = edge_phase_reg;
        delay_count_next   = delay_count_reg;
        byte_active_next   = byte_active_reg;
        select_active_next = select_active_reg;
        ending_next        = ending_reg;
        rx_valid_next      = 1'b0;
        ready_res_next     = 1'b0;
        done_next          = 1'b0;

        if (!byte_active_reg) begin
            if (s_action) begin
                tx_shift_next      = s_tx_present ? tx_ext[WORD_BITS-1:0] : '1;
                rx_shift_next      = '0;
                bit_index_next     = LAST_IDX;
                edge_phase_next    = 1'b0;
                delay_count_next   = '0;
                byte_active_next   = 1'b1;
                select_active_next = 1'b1;
                ending_next        = s_last_byte;
                ready_res_next     = 1'b1;
            end
        end else begin
            delay_count_next = delay_inc;
            if (delay_inc >= period) begin
                delay_count_next = '0;
                if (!edge_phase_reg) begin
                    edge_phase_next = 1'b1;
                end else begin
                    rx_shift_next   = {rx_shift_reg[WORD_BITS-2:0], s_miso_level};
                    edge_phase_next = 1'b0;
                    if (bit_index_reg == '0) begin
                        byte_active_next = 1'b0;
                        rx_valid_next    = 1'b1;
                        if (ending_reg) begin
                            select_active_next = 1'b0;
                            ending_next        = 1'b0;
                            done_next          = 1'b1;
                        end
                    end else begin
                        bit_index_next = bit_index_reg - IDX_W'(1);
                    end
                end
            end
        end

        // Pin levels after this tick
        sclk_at_active = byte_active_next &&
                         (sample_second_reg ? !edge_phase_next : edge_phase_next);
        sclk_next   = sclk_at_active ? !clock_idle_high_reg : clock_idle_high_reg;
        mosi_next   = tx_shift_next[bit_index_next];
        rx_ext      = EXT_W'(rx_shift_next);
        rx_byte_next = rx_valid_next ? rx_ext[BYTE_W-1:0] : '0;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_idle_high_reg <= 1'b0;
            sample_second_reg   <= 1'b0;
            half_period_reg     <= HALF_PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CLOCK_IDLE_HIGH:       clock_idle_high_reg <= cfg_data[0];
                CFG_SAMPLE_ON_SECOND_EDGE: sample_second_reg   <= cfg_data[0];
                CFG_HALF_PERIOD_TICKS:     half_period_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Engine state, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_shift_reg      <= '0;
            rx_shift_reg      <= '0;
            bit_index_reg     <= LAST_IDX;
            edge_phase_reg    <= 1'b0;
            delay_count_reg   <= '0;
            byte_active_reg   <= 1'b0;
            select_active_reg <= 1'b0;
            ending_reg        <= 1'b0;
        end else if (s_take) begin
            tx_shift_reg      <= tx_shift_next;
            rx_shift_reg      <= rx_shift_next;
            bit_index_reg     <= bit_index_next;
            edge_phase_reg    <= edge_phase_next;
            delay_count_reg   <= delay_count_next;
            byte_active_reg   <= byte_active_next;
            select_active_reg <= select_active_next;
            ending_reg        <= ending_next;
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            sclk_reg      <= sclk_next;
            mosi_reg      <= mosi_next;
            csn_reg       <= !select_active_next;
            rx_byte_reg   <= rx_byte_next;
            rx_valid_reg  <= rx_valid_next;
            ready_res_reg <= ready_res_next;
            done_reg      <= done_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sclk_level    = sclk_reg;
    assign m_mosi_level    = mosi_reg;
    assign m_chip_select_n = csn_reg;
    assign m_rx_byte       = rx_byte_reg;
    assign m_rx_valid      = rx_valid_reg;
    assign m_ready_res     = ready_res_reg;
    assign m_transfer_done = done_reg;

endmodule

[test/spime_pin_checker.sv]
// Pin level predictor and result checker for spi_master_mode_engine.
// Depends on spime_pkg; watches the config, tick and result channels.
module spime_pin_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [spime_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spime_pkg::HALF_W-1:0]    cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_action,
    input  logic [spime_pkg::BYTE_W-1:0]    s_tx_byte,
    input  logic                            s_tx_present,
    input  logic                            s_last_byte,
    input  logic                            s_miso_level,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_sclk_level,
    input  logic                            m_mosi_level,
    input  logic                            m_chip_select_n,
    input  logic [spime_pkg::BYTE_W-1:0]    m_rx_byte,
    input  logic                            m_rx_valid,
    input  logic                            m_ready_res,
    input  logic                            m_transfer_done,
    output int                              mismatches,
    output int                              levels_pending
);
    import spime_pkg::*;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              csn;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              ready_res;
        logic              done;
    } pin_levels_t;

    // Which half of the current bit the engine is in
    typedef enum logic [1:0] {
        HALF_LEAD  = 2'd0,
        HALF_TRAIL = 2'd1
    } bit_half_t;

    localparam int BITS = WORD_BITS_DEF;

    // Register copies
    logic              idle_high;
    logic              second_edge;
    logic [HALF_W-1:0] half_ticks;

    // Engine state copy
    logic [BITS-1:0]   tx_word;
    logic [BITS-1:0]   rx_word;
    logic [2:0]        bit_pos;
    bit_half_t         half;
    logic [HALF_W-1:0] tick_count;
    logic              shifting;
    logic              selected;
    logic              closing;

    pin_levels_t pin_levels_due[$];
    int          results_seen;

    // Advance the engine by one timing tick and return the pin levels after it
    function automatic pin_levels_t advance_spi_tick(logic action, logic [BYTE_W-1:0] tx,
                                                     logic present, logic last,
                                                     logic miso);
        pin_levels_t       lv;
        logic [HALF_W-1:0] period;
        logic              active;
        lv = '0;
        period = (half_ticks == '0) ? HALF_W'(1) : half_ticks;
        if (!shifting) begin
            if (action) begin
                tx_word    = present ? tx : '1;
                rx_word    = '0;
                bit_pos    = 3'(BITS - 1);
                half       = HALF_LEAD;
                tick_count = '0;
                shifting   = 1'b1;
                selected   = 1'b1;
                closing    = last;
                lv.ready_res = 1'b1;
            end
        end else begin
            tick_count = tick_count + HALF_W'(1);
            if (tick_count >= period) begin
                tick_count = '0;
                if (half == HALF_LEAD) begin
                    half = HALF_TRAIL;
                end else begin
                    rx_word = {rx_word[BITS-2:0], miso};
                    half = HALF_LEAD;
                    if (bit_pos == '0) begin
                        shifting    = 1'b0;
                        lv.rx_valid = 1'b1;
                        lv.rx_byte  = rx_word;
                        if (closing) begin
                            selected = 1'b0;
                            closing  = 1'b0;
                            lv.done  = 1'b1;
                        end
                    end else begin
                        bit_pos = bit_pos - 3'(1);
                    end
                end
            end
        end
        // Pin levels from the updated state and current registers
        active  = shifting && (second_edge ? (half == HALF_LEAD) : (half == HALF_TRAIL));
        lv.sclk = active ? ~idle_high : idle_high;
        lv.mosi = tx_word[bit_pos];
        lv.csn  = ~selected;
        return lv;
    endfunction

    always @(posedge aclk) begin
        pin_levels_t got;
        pin_levels_t want;
        if (!aresetn) begin
            idle_high      = 1'b0;
            second_edge    = 1'b0;
            half_ticks     = HALF_PERIOD_RESET;
            tx_word        = '0;
            rx_word        = '0;
            bit_pos        = 3'(BITS - 1);
            half           = HALF_LEAD;
            tick_count     = '0;
            shifting       = 1'b0;
            selected       = 1'b0;
            closing        = 1'b0;
            pin_levels_due.delete();
            results_seen   = 0;
            mismatches     = 0;
            levels_pending = 0;
        end else begin
            // Register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CLOCK_IDLE_HIGH:       idle_high   = cfg_data[0];
                    CFG_SAMPLE_ON_SECOND_EDGE: second_edge = cfg_data[0];
                    CFG_HALF_PERIOD_TICKS:     half_ticks  = cfg_data;
                    default: ;
                endcase
            end
            // Compare an accepted result with the oldest expectation
            if (m_valid && m_ready) begin
                got = '{m_sclk_level, m_mosi_level, m_chip_select_n, m_rx_byte,
                        m_rx_valid, m_ready_res, m_transfer_done};
                if (pin_levels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %0d: %p", results_seen, got);
                end else begin
                    want = pin_levels_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: sclk %b/%b mosi %b/%b csn %b/%b",
                                      " rx %h/%h rxv %b/%b rdy %b/%b done %b/%b (exp/act)"},
                                     results_seen, want.sclk, got.sclk, want.mosi, got.mosi,
                                     want.csn, got.csn, want.rx_byte, got.rx_byte,
                                     want.rx_valid, got.rx_valid, want.ready_res,
                                     got.ready_res, want.done, got.done);
                    end
                end
                results_seen++;
            end
            // Predict for an accepted tick
            if (s_valid && s_ready)
                pin_levels_due.push_back(advance_spi_tick(s_action, s_tx_byte, s_tx_present,
                                                          s_last_byte, s_miso_level));
            levels_pending = pin_levels_due.size();
        end
    end

endmodule

[test/spi_master_mode_engine_tb.sv]
// Top testbench for spi_master_mode_engine: clock, reset, tick stimulus and verdict.
// Depends on spime_pkg, spi_master_mode_engine and spime_pin_checker.
module spi_master_mode_engine_tb;
    import spime_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_action;
    logic [BYTE_W-1:0]    s_tx_byte;
    logic                 s_tx_present;
    logic                 s_last_byte;
    logic                 s_miso_level;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_sclk_level;
    logic                 m_mosi_level;
    logic                 m_chip_select_n;
    logic [BYTE_W-1:0]    m_rx_byte;
    logic                 m_rx_valid;
    logic                 m_ready_res;
    logic                 m_transfer_done;

    int   mismatches;
    int   levels_pending;
    int   cycle_count;
    int   hold_left;
    logic hold_req;
    logic calm;

    spi_master_mode_engine uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_tx_present    (s_tx_present),
        .s_last_byte     (s_last_byte),
        .s_miso_level    (s_miso_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sclk_level    (m_sclk_level),
        .m_mosi_level    (m_mosi_level),
        .m_chip_select_n (m_chip_select_n),
        .m_rx_byte       (m_rx_byte),
        .m_rx_valid      (m_rx_valid),
        .m_ready_res     (m_ready_res),
        .m_transfer_done (m_transfer_done)
    );

    spime_pin_checker pin_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_tx_present    (s_tx_present),
        .s_last_byte     (s_last_byte),
        .s_miso_level    (s_miso_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sclk_level    (m_sclk_level),
        .m_mosi_level    (m_mosi_level),
        .m_chip_select_n (m_chip_select_n),
        .m_rx_byte       (m_rx_byte),
        .m_rx_valid      (m_rx_valid),
        .m_ready_res     (m_ready_res),
        .m_transfer_done (m_transfer_done),
        .mismatches      (mismatches),
        .levels_pending  (levels_pending)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 79;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Offer one tick item; starts and ends at a falling edge, valid left high
    task automatic send_tick(logic action, logic [BYTE_W-1:0] tx, logic present,
                             logic last, logic miso);
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= action;
        s_tx_byte    <= tx;
        s_tx_present <= present;
        s_last_byte  <= last;
        s_miso_level <= miso;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register write; valid left high for back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (levels_pending != 0) @(negedge aclk);
    endtask

    // Stimulus and verdict
    initial begin
        logic              idle_lvl;
        logic              late_edge;
        logic [HALF_W-1:0] half_ticks;
        int                n_items;
        int                load_pct;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_action     = 1'b0;
        s_tx_byte    = '0;
        s_tx_present = 1'b0;
        s_last_byte  = 1'b0;
        s_miso_level = 1'b0;
        hold_req     = 1'b0;
        calm         = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset pins, one full word with loads while busy,
        // a load on the completing tick, then a read-only closing word
        send_tick(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 8'hA5, 1'b1, 1'b0, 1'b1);
        for (int i = 1; i <= 16; i++)
            send_tick((i == 16) || (i % 5 == 0), 8'h3C, 1'b1, 1'b1, i[0]);
        send_tick(1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            send_tick(1'b0, 8'hFF, 1'b1, 1'b0, 1'b1);
        drain_results();

        // Random phases over the clock modes and half period settings
        for (int p = 0; p < PHASES; p++) begin
            idle_lvl   = 1'($urandom_range(0, 1));
            late_edge  = 1'($urandom_range(0, 1));
            half_ticks = HALF_W'($urandom_range(1, 4));
            case (p)
                0: begin idle_lvl = 1'b0; late_edge = 1'b0; half_ticks = 16'd1;     end
                1: begin idle_lvl = 1'b1; late_edge = 1'b0; half_ticks = 16'd2;     end
                2: begin idle_lvl = 1'b0; late_edge = 1'b1; half_ticks = 16'd0;     end
                3: begin idle_lvl = 1'b1; late_edge = 1'b1; half_ticks = 16'd3;     end
                4: begin idle_lvl = 1'b0; late_edge = 1'b0; half_ticks = 16'hFFFF;  end
                5: begin idle_lvl = 1'b1; late_edge = 1'b1; half_ticks = 16'd1;     end
                default: ;
            endcase
            write_reg(CFG_CLOCK_IDLE_HIGH, {15'h7FFF, idle_lvl});
            write_reg(CFG_SAMPLE_ON_SECOND_EDGE, {15'h0000, late_edge});
            write_reg(CFG_HALF_PERIOD_TICKS, half_ticks);
            if (p == 2)
                write_reg(CFG_UNUSED, HALF_W'($urandom));
            cfg_valid <= 1'b0;
            @(negedge aclk);

            // Long half period only briefly; the next phase finishes the word
            n_items = (p == 4) ? 40 : 146;
            calm = (p == 5);
            if (p == 1)
                hold_req = 1'b1;
            load_pct = 60;
            for (int i = 0; i < n_items; i++) begin
                if (i % 40 == 0)
                    load_pct = ($urandom_range(0, 2) == 0) ? 6 : 60;
                send_tick($urandom_range(0, 99) < load_pct, BYTE_W'($urandom),
                          $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 35,
                          1'($urandom_range(0, 1)));
            end
            drain_results();
            calm = 1'b0;
        end

        repeat (5) @(negedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
